// ===== sv/mcfe_pkg.sv =====
// shared types and constants for the motor command frame encoder
// no dependencies; imported by every module of the block
package mcfe_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int LIMIT_W           = 31;
    localparam int QUANT_STAGES      = 16;
    localparam int QUANT_W           = 16;

    // request codes, 3'd7 is unused
    typedef enum logic [2:0] {
        REQ_ENABLE   = 3'd0,
        REQ_DISABLE  = 3'd1,
        REQ_MIT      = 3'd2,
        REQ_POS_SPD  = 3'd3,
        REQ_SPD      = 3'd4,
        REQ_POS_CUR  = 3'd5,
        REQ_FEEDBACK = 3'd6
    } t_req;

    // configuration register indexes
    localparam logic [2:0] CFG_POSITION_LIMIT  = 3'd0;
    localparam logic [2:0] CFG_SPEED_LIMIT     = 3'd1;
    localparam logic [2:0] CFG_STIFFNESS_LIMIT = 3'd2;
    localparam logic [2:0] CFG_DAMPING_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_TORQUE_LIMIT    = 3'd4;

    localparam logic [LIMIT_W-1:0] RST_POSITION_LIMIT  = 31'd819200;
    localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT     = 31'd1966080;
    localparam logic [LIMIT_W-1:0] RST_STIFFNESS_LIMIT = 31'd32768000;
    localparam logic [LIMIT_W-1:0] RST_DAMPING_LIMIT   = 31'd327680;
    localparam logic [LIMIT_W-1:0] RST_TORQUE_LIMIT    = 31'd655360;

    localparam logic [11:0] BROADCAST_ID   = 12'h7FF;
    localparam logic [11:0] OFS_POS_SPD    = 12'h100;
    localparam logic [11:0] OFS_SPD        = 12'h200;
    localparam logic [11:0] OFS_POS_CUR    = 12'h300;
    localparam logic [7:0]  CMD_ENABLE     = 8'hFC;
    localparam logic [7:0]  CMD_DISABLE    = 8'hFD;
    localparam logic [7:0]  CMD_WRITE_REG  = 8'h55;
    localparam logic [7:0]  CMD_FEEDBACK   = 8'hCC;
    localparam logic [7:0]  REG_CTRL_MODE  = 8'd10;
    localparam logic [13:0] SPEED_SCALE    = 14'd100;
    localparam logic [13:0] CURRENT_SCALE  = 14'd10000;

    typedef struct packed {
        logic [11:0] id;
        logic [31:0] lo;
        logic [31:0] hi;
        logic        last;
    } t_frame;

endpackage

// ===== sv/mcfe_quant.sv =====
// clamp and quantize one value to floor(x*(2^BITS-1)/range), pipelined
// restoring divider, one quotient bit per stage; depends on mcfe_pkg
module mcfe_quant import mcfe_pkg::*; #(
    parameter int BITS      = 12,
    parameter bit SYMMETRIC = 1'b1
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [31:0]        i_value,
    input  logic [LIMIT_W-1:0]        i_limit,
    output logic [QUANT_W-1:0]        o_q
);

    localparam int RW = 33 + QUANT_W;

    logic [32:0]         r_x;
    logic [RW-1:0]       r_rem [0:QUANT_STAGES];
    logic [QUANT_W-1:0]  r_quo [0:QUANT_STAGES];
    logic [32:0]         n_x;
    logic [31:0]         w_div;
    logic signed [32:0]  w_v;
    logic signed [32:0]  w_l;

    always_comb begin
        w_v = {i_value[31], i_value};
        w_l = {2'b00, i_limit};
        if (SYMMETRIC) begin
            if (w_v < -w_l) begin
                n_x = 33'd0;
            end else if (w_v > w_l) begin
                n_x = 33'(w_l + w_l);
            end else begin
                n_x = 33'(w_v + w_l);
            end
            w_div = {i_limit, 1'b0};
        end else begin
            if (w_v < 33'sd0) begin
                n_x = 33'd0;
            end else if (w_v > w_l) begin
                n_x = 33'(w_l);
            end else begin
                n_x = 33'(w_v);
            end
            w_div = {1'b0, i_limit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x      <= n_x;
            // x * (2^BITS - 1) as shift and subtract
            r_rem[0] <= (RW'(r_x) << BITS) - RW'(r_x);
            r_quo[0] <= '0;
        end
    end

    genvar k;
    for (k = 0; k < QUANT_STAGES; k++) begin : g_div
        logic [RW-1:0] w_dsh;
        logic          w_ge;
        assign w_dsh = RW'(w_div) << (QUANT_STAGES - 1 - k);
        assign w_ge  = r_rem[k] >= w_dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? r_rem[k] - w_dsh : r_rem[k];
                r_quo[k+1] <= {r_quo[k][QUANT_W-2:0], w_ge};
            end
        end
    end

    // the user must change limits only while idle, which the block does not enforce; the live value here relies on that
    assign o_q = (i_limit == '0) ? '0 : r_quo[QUANT_STAGES];

endmodule

// ===== sv/mcfe_f2s.sv =====
// signed fixed point to ieee single, round to nearest even, four stages
// depends on mcfe_pkg
module mcfe_f2s import mcfe_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_value,
    output logic [31:0] o_single
);

    localparam logic [7:0] EXP_TOP = 8'(157 - FRACTION_BITS);

    logic        r1_sign, r2_sign, r3_sign;
    logic [31:0] r1_mag, r2_m, r3_m;
    logic [1:0]  r2_lz;
    logic [4:0]  r3_lz;
    logic [31:0] r_res;

    logic [31:0] w_m1, w_m2, w_m3, w_m4, w_m5;
    logic        w_l4, w_l3, w_l2, w_l1, w_l0;
    logic [24:0] w_mant;
    logic        w_inc;
    logic [7:0]  w_exp;

    always_comb begin
        w_l4 = r1_mag[31:16] == '0;
        w_m1 = w_l4 ? r1_mag << 16 : r1_mag;
        w_l3 = w_m1[31:24] == '0;
        w_m2 = w_l3 ? w_m1 << 8 : w_m1;

        w_l2 = r2_m[31:28] == '0;
        w_m3 = w_l2 ? r2_m << 4 : r2_m;
        w_l1 = w_m3[31:30] == '0;
        w_m4 = w_l1 ? w_m3 << 2 : w_m3;
        w_l0 = !w_m4[31];
        w_m5 = w_l0 ? w_m4 << 1 : w_m4;

        // guard bit 7, sticky below it
        w_inc  = r3_m[7] && ((|r3_m[6:0]) || r3_m[8]);
        w_mant = {1'b0, r3_m[31:8]} + 25'(w_inc);
        w_exp  = EXP_TOP - {3'b000, r3_lz};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sign <= i_value[31];
            r1_mag  <= i_value[31] ? 32'(-i_value) : i_value;
            r2_sign <= r1_sign;
            r2_m    <= w_m2;
            r2_lz   <= {w_l4, w_l3};
            r3_sign <= r2_sign;
            r3_m    <= w_m5;
            r3_lz   <= {r2_lz, w_l2, w_l1, w_l0};
            if (!r3_m[31]) begin
                r_res <= '0;
            end else begin
                r_res <= {r3_sign, 31'd0} | ({1'b0, w_exp, 23'd0} + {7'd0, w_mant});
            end
        end
    end

    assign o_single = r_res;

endmodule

// ===== sv/motor_command_frame_encoder.sv =====
// top level of the motor command frame encoder: stream in, frames out
// depends on mcfe_pkg, mcfe_quant and mcfe_f2s
//
// One command enters per cycle, while s_tready is high, into a 21-register pipeline (input
// register, 18 stages set by the 16-step quantizing divider, frame build, output register).
// Enable, disable and feedback request give one frame; the four set commands give a
// mode-switch frame and then the command frame, so s_tready stays low for those until
// their second frame has been loaded into the output register.
module motor_command_frame_encoder import mcfe_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [LIMIT_W-1:0]  i_cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // motor_id[10:0], position_value[42:11], speed_value[74:43],
    // stiffness_value[106:75], damping_value[138:107], effort_value[170:139]
    input  logic [175:0]        s_tdata,
    // req_type[2:0]
    input  logic [2:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // msg_id[11:0], payload_low[43:12], payload_high[75:44]
    output logic [79:0]         m_tdata,
    output logic                m_tlast
);

    localparam int QLAT    = 2 + QUANT_STAGES;
    localparam int FPAD    = QLAT - 4;
    localparam int SPAD    = QLAT - 3;

    logic [LIMIT_W-1:0] r_pos_lim, r_spd_lim, r_kp_lim, r_kd_lim, r_tq_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_lim <= RST_POSITION_LIMIT;
            r_spd_lim <= RST_SPEED_LIMIT;
            r_kp_lim  <= RST_STIFFNESS_LIMIT;
            r_kd_lim  <= RST_DAMPING_LIMIT;
            r_tq_lim  <= RST_TORQUE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POSITION_LIMIT:  r_pos_lim <= i_cfg_data;
                CFG_SPEED_LIMIT:     r_spd_lim <= i_cfg_data;
                CFG_STIFFNESS_LIMIT: r_kp_lim  <= i_cfg_data;
                CFG_DAMPING_LIMIT:   r_kd_lim  <= i_cfg_data;
                CFG_TORQUE_LIMIT:    r_tq_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic   adv;
    logic   o_load;
    logic   e_done;
    logic   r_e_valid, r_e_two, r_ph;
    t_frame r_e_f0, r_e_f1;
    logic   r_o_valid;
    t_frame r_o;

    assign o_load   = !r_o_valid || m_tready;
    assign e_done   = o_load && r_e_valid && (!r_e_two || r_ph);
    assign adv      = !r_e_valid || e_done;
    assign s_tready = adv;

    // input register
    logic               r_s1_valid;
    t_req               r_s1_req;
    logic [10:0]        r_s1_id;
    logic signed [31:0] r_s1_pos, r_s1_spd, r_s1_kp, r_s1_kd, r_s1_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_req <= t_req'(s_tuser);
            r_s1_id  <= s_tdata[10:0];
            r_s1_pos <= s_tdata[42:11];
            r_s1_spd <= s_tdata[74:43];
            r_s1_kp  <= s_tdata[106:75];
            r_s1_kd  <= s_tdata[138:107];
            r_s1_eff <= s_tdata[170:139];
        end
    end

    // quantizers
    logic [QUANT_W-1:0] w_qp, w_qs, w_qk, w_qd, w_qt;

    mcfe_quant #(.BITS(16), .SYMMETRIC(1'b1)) u_q_pos (
        .i_clk(i_clk), .i_en(adv), .i_value(r_s1_pos), .i_limit(r_pos_lim), .o_q(w_qp)
    );
    mcfe_quant #(.BITS(12), .SYMMETRIC(1'b1)) u_q_spd (
        .i_clk(i_clk), .i_en(adv), .i_value(r_s1_spd), .i_limit(r_spd_lim), .o_q(w_qs)
    );
    mcfe_quant #(.BITS(12), .SYMMETRIC(1'b0)) u_q_kp (
        .i_clk(i_clk), .i_en(adv), .i_value(r_s1_kp), .i_limit(r_kp_lim), .o_q(w_qk)
    );
    mcfe_quant #(.BITS(12), .SYMMETRIC(1'b0)) u_q_kd (
        .i_clk(i_clk), .i_en(adv), .i_value(r_s1_kd), .i_limit(r_kd_lim), .o_q(w_qd)
    );
    mcfe_quant #(.BITS(12), .SYMMETRIC(1'b1)) u_q_tq (
        .i_clk(i_clk), .i_en(adv), .i_value(r_s1_eff), .i_limit(r_tq_lim), .o_q(w_qt)
    );

    // float conversions
    logic [31:0] w_fpos, w_fspd;

    mcfe_f2s #(.FRACTION_BITS(FRACTION_BITS)) u_f_pos (
        .i_clk(i_clk), .i_en(adv), .i_value(r_s1_pos), .o_single(w_fpos)
    );
    mcfe_f2s #(.FRACTION_BITS(FRACTION_BITS)) u_f_spd (
        .i_clk(i_clk), .i_en(adv), .i_value(r_s1_spd), .o_single(w_fspd)
    );

    // scaled speed and current, truncated toward zero
    logic        r_sa_nspd, r_sa_neff, r_sb_nspd, r_sb_neff;
    logic [31:0] r_sa_spd, r_sa_eff;
    logic [45:0] r_sb_spd, r_sb_eff;
    logic [31:0] r_sc;
    logic [15:0] w_ms, w_me;

    assign w_ms = r_sb_spd[FRACTION_BITS +: 16];
    assign w_me = r_sb_eff[FRACTION_BITS +: 16];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sa_nspd <= r_s1_spd[31];
            r_sa_neff <= r_s1_eff[31];
            r_sa_spd  <= r_s1_spd[31] ? 32'(-r_s1_spd) : r_s1_spd;
            r_sa_eff  <= r_s1_eff[31] ? 32'(-r_s1_eff) : r_s1_eff;
            r_sb_nspd <= r_sa_nspd;
            r_sb_neff <= r_sa_neff;
            r_sb_spd  <= 46'(r_sa_spd) * 46'(SPEED_SCALE);
            r_sb_eff  <= 46'(r_sa_eff) * 46'(CURRENT_SCALE);
            r_sc      <= {r_sb_neff ? 16'(-w_me) : w_me, r_sb_nspd ? 16'(-w_ms) : w_ms};
        end
    end

    // alignment lines
    logic        r_mv   [0:QLAT-1];
    t_req        r_mreq [0:QLAT-1];
    logic [10:0] r_mid  [0:QLAT-1];
    logic [31:0] r_fp   [0:FPAD-1];
    logic [31:0] r_fs   [0:FPAD-1];
    logic [31:0] r_sd   [0:SPAD-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QLAT; i++) begin
                r_mv[i] <= 1'b0;
            end
        end else if (adv) begin
            r_mv[0] <= r_s1_valid;
            for (int i = 1; i < QLAT; i++) begin
                r_mv[i] <= r_mv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mreq[0] <= r_s1_req;
            r_mid[0]  <= r_s1_id;
            for (int i = 1; i < QLAT; i++) begin
                r_mreq[i] <= r_mreq[i-1];
                r_mid[i]  <= r_mid[i-1];
            end
            r_fp[0] <= w_fpos;
            r_fs[0] <= w_fspd;
            for (int i = 1; i < FPAD; i++) begin
                r_fp[i] <= r_fp[i-1];
                r_fs[i] <= r_fs[i-1];
            end
            r_sd[0] <= r_sc;
            for (int i = 1; i < SPAD; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    // frame build
    t_req        a_req;
    logic [10:0] a_id;
    logic [15:0] a_idb;
    t_frame      n_f0, n_f1;
    logic        n_two, n_some;

    assign a_req = r_mreq[QLAT-1];
    assign a_id  = r_mid[QLAT-1];
    assign a_idb = {5'd0, a_id};

    always_comb begin
        n_f0.id   = BROADCAST_ID;
        n_f0.lo   = {REG_CTRL_MODE, CMD_WRITE_REG, a_idb};
        n_f0.hi   = 32'(a_req) - 32'd1;
        n_f0.last = 1'b0;
        n_f1.id   = {1'b0, a_id};
        n_f1.lo   = '1;
        n_f1.hi   = '0;
        n_f1.last = 1'b1;
        n_two     = 1'b1;
        n_some    = 1'b1;
        case (a_req)
            REQ_ENABLE: begin
                n_f1.hi = {CMD_ENABLE, 24'hFFFFFF};
                n_two   = 1'b0;
            end
            REQ_DISABLE: begin
                n_f1.hi = {CMD_DISABLE, 24'hFFFFFF};
                n_two   = 1'b0;
            end
            REQ_FEEDBACK: begin
                n_f1.id = BROADCAST_ID;
                n_f1.lo = {8'd0, CMD_FEEDBACK, a_idb};
                n_two   = 1'b0;
            end
            REQ_MIT: begin
                n_f1.lo = {w_qs[3:0], w_qk[11:8], w_qs[11:4], w_qp[7:0], w_qp[15:8]};
                n_f1.hi = {w_qt[7:0], w_qd[3:0], w_qt[11:8], w_qd[11:4], w_qk[7:0]};
            end
            REQ_POS_SPD: begin
                n_f1.id = {1'b0, a_id} + OFS_POS_SPD;
                n_f1.lo = r_fp[FPAD-1];
                n_f1.hi = r_fs[FPAD-1];
            end
            REQ_SPD: begin
                n_f1.id = {1'b0, a_id} + OFS_SPD;
                n_f1.lo = r_fs[FPAD-1];
            end
            REQ_POS_CUR: begin
                n_f1.id = {1'b0, a_id} + OFS_POS_CUR;
                n_f1.lo = r_fp[FPAD-1];
                n_f1.hi = r_sd[SPAD-1];
            end
            default: begin
                n_some = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (adv) begin
            r_e_valid <= r_mv[QLAT-1] && n_some;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_f0  <= n_f0;
            r_e_f1  <= n_f1;
            r_e_two <= n_two;
        end
    end

    // frame emitter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_ph      <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= r_e_valid;
            if (r_e_valid) begin
                r_ph <= r_e_two && !r_ph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && r_e_valid) begin
            r_o <= (r_e_two && !r_ph) ? r_e_f0 : r_e_f1;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = {4'd0, r_o.hi, r_o.lo, r_o.id};
    assign m_tlast  = r_o.last;

endmodule
